// File: sv/mprl_pkg.sv
// Package for the marker pair robot locator: field widths, operation and
// status codes, CORDIC arctangent table. No dependencies.
package mprl_pkg;
  localparam int CoordW = 12;
  localparam int HeadW = 16;
  localparam int AccW = 32;
  localparam int MaxMarkersDef = 64;
  localparam int AngleItersDef = 16;
  localparam int AtanLen = 24;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  function automatic logic [AccW-1:0] atan_of(input logic [4:0] i);
    logic [AccW-1:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;
        5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
        5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
        5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

// File: sv/mprl_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Depends on mprl_pkg.
module mprl_cordic import mprl_pkg::*; #(
  parameter int ANGLE_ITERATIONS = AngleItersDef
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CoordW:0]  dx,
  input  logic signed [CoordW:0]  dy,
  output logic                    done,
  output logic [HeadW-1:0]        heading
);
  localparam int Iters = (ANGLE_ITERATIONS < AtanLen) ? ANGLE_ITERATIONS : AtanLen;
  // 13-bit deltas scaled by 2^16 plus CORDIC gain headroom
  localparam int VW = CoordW + 1 + 16 + 3;

  logic signed [VW-1:0] x, y;
  logic [AccW-1:0] acc;
  logic [4:0] iter;
  logic busy;
  logic signed [VW-1:0] xs, ys;
  logic [AccW-1:0] rnd;

  assign xs = x >>> iter;
  assign ys = y >>> iter;
  assign rnd = acc + AccW'(32'h8000);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
        if (dx < 0) begin
          x <= -(VW'(dx) <<< 16);
          y <= -(VW'(dy) <<< 16);
          acc <= 32'h80000000;
        end else begin
          x <= VW'(dx) <<< 16;
          y <= VW'(dy) <<< 16;
          acc <= '0;
        end
        if (dx == 0 && dy == 0) begin
          busy <= 1'b0;
          done <= 1'b1;
          heading <= '0;
        end
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          acc <= acc + atan_of(iter);
        end else begin
          x <= x - ys;
          y <= y + xs;
          acc <= acc - atan_of(iter);
        end
        iter <= iter + 5'd1;
        if (iter == 5'(Iters)) begin
          busy <= 1'b0;
          done <= 1'b1;
          heading <= rnd[AccW-1:AccW-HeadW];
        end
      end
    end
  end
endmodule

// File: sv/marker_pair_robot_locator_unit.sv
// Marker pair robot locator: marker store, two-nearest scan, CORDIC heading.
// Clear, load, an unused code or an empty locate are answered directly from idle;
// a locate scans the store and then runs the CORDIC heading, whose iterations are
// skipped when the team point sits on the nearest marker. One transaction at a time:
// the next input is taken the cycle after the result is accepted.
// Synchronous reset empties the store (count 0) and drops any pending result.
module marker_pair_robot_locator_unit import mprl_pkg::*; #(
  parameter int MAX_MARKERS = MaxMarkersDef,
  parameter int ANGLE_ITERATIONS = AngleItersDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // operation[1:0], marker_group, x_coord, y_coord
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status, robot_id, robot_x, robot_y, heading
);
  localparam int AW = $clog2(MAX_MARKERS);
  localparam int CW = $clog2(MAX_MARKERS + 1);
  localparam int DW = 2 * CoordW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_FETCH = 3'd2,
                         S_ANGLE = 3'd4;

  logic [2:0] state;
  logic [2*CoordW:0] mem [MAX_MARKERS];
  logic [2*CoordW:0] rd;
  logic [CW-1:0] count, idx;
  logic [AW-1:0] raddr;
  logic rd_ok;
  logic [CW-1:0] rd_idx;
  logic [CoordW-1:0] px, py;
  logic [DW-1:0] bd, sd, d;
  logic have2, g1, g2;
  logic [CoordW-1:0] bx, by;
  logic signed [CoordW:0] ex, ey;
  logic [2*CoordW+1:0] ex2, ey2;
  logic [47:0] out;
  logic cstart, cdone;
  logic [HeadW-1:0] head;

  logic [1:0] op;
  assign op = s_tdata[1:0];
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign m_tdata = out;

  assign ex = $signed({1'b0, px}) - $signed({1'b0, rd[2*CoordW-1:CoordW]});
  assign ey = $signed({1'b0, py}) - $signed({1'b0, rd[CoordW-1:0]});
  assign ex2 = (2*CoordW+2)'(ex * ex);
  assign ey2 = (2*CoordW+2)'(ey * ey);
  assign d = DW'(ex2 + ey2);
  assign raddr = idx[AW-1:0];

  always_ff @(posedge clk) begin
    rd <= mem[raddr];
    if (s_tvalid && s_tready && op == OP_LOAD && count < CW'(MAX_MARKERS))
      mem[count[AW-1:0]] <= {s_tdata[2], s_tdata[14:3], s_tdata[26:15]};
  end

  mprl_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart),
    .dx($signed({1'b0, px}) - $signed({1'b0, bx})),
    .dy($signed({1'b0, py}) - $signed({1'b0, by})),
    .done(cdone), .heading(head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      m_tvalid <= 1'b0;
      cstart <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      cstart <= 1'b0;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            px <= s_tdata[14:3];
            py <= s_tdata[26:15];
            if (op == OP_CLEAR) begin
              count <= '0;
              out <= '0;
              m_tvalid <= 1'b1;
            end else if (op == OP_LOAD) begin
              if (count < CW'(MAX_MARKERS)) begin
                count <= count + CW'(1);
                out <= '0;
              end else begin
                out <= 48'(ST_FULL);
              end
              m_tvalid <= 1'b1;
            end else if (op == OP_LOCATE) begin
              if (count == '0) begin
                out <= 48'(ST_EMPTY);
                m_tvalid <= 1'b1;
              end else begin
                idx <= '0;
                have2 <= 1'b0;
                g2 <= 1'b0;
                rd_ok <= 1'b0;
                state <= S_SCAN;
              end
            end else begin
              out <= '0;
              m_tvalid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // issue read for idx, evaluate the entry read last cycle
          rd_ok <= (idx < count);
          rd_idx <= idx;
          if (idx < count) idx <= idx + CW'(1);
          if (rd_ok) begin
            if (rd_idx == '0) begin
              bd <= d; bx <= rd[2*CoordW-1:CoordW]; by <= rd[CoordW-1:0];
              g1 <= rd[2*CoordW];
            end else if (d < bd) begin
              sd <= bd; g2 <= g1; have2 <= 1'b1;
              bd <= d; bx <= rd[2*CoordW-1:CoordW]; by <= rd[CoordW-1:0];
              g1 <= rd[2*CoordW];
            end else if (!have2 || d < sd) begin
              sd <= d; g2 <= rd[2*CoordW]; have2 <= 1'b1;
            end
          end else if (idx == count && rd_idx != '0) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          cstart <= 1'b1;
          state <= S_ANGLE;
        end
        S_ANGLE: begin
          if (cdone) begin
            out <= {4'b0, head, by, bx, g1, g2, ST_OK};
            m_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: bench/marker_pair_robot_locator_checker.sv
// Checker for the marker pair robot locator: watches both stream channels,
// predicts each result from its own marker store and compares. Uses mprl_pkg.
`timescale 1ns / 100ps
module marker_pair_robot_locator_checker import mprl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          locates_seen,
  output int          full_seen
);
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  robot_id;
    logic [11:0] robot_x;
    logic [11:0] robot_y;
    logic [15:0] heading;
  } locate_result_t;

  logic [24:0] markers [MaxMarkersDef];
  int unsigned marker_total;
  locate_result_t expected_results[$];

  // Vectoring CORDIC, 16 steps, floor shifts
  function automatic logic [15:0] cordic_heading(input int dx, input int dy);
    longint x, y, nx, ny;
    logic [31:0] acc;
    acc = '0;
    if (dx == 0 && dy == 0) return '0;
    x = longint'(dx) * 65536;
    y = longint'(dy) * 65536;
    if (dx < 0) begin
      x = -x;
      y = -y;
      acc = 32'h80000000;
    end
    for (int i = 0; i < AngleItersDef; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        acc = acc + atan_of(5'(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        acc = acc - atan_of(5'(i));
      end
      x = nx;
      y = ny;
    end
    acc = acc + 32'h8000;
    return acc[31:16];
  endfunction

  function automatic locate_result_t predict_marker_result(input logic [31:0] d);
    locate_result_t r;
    logic [1:0] op;
    int px, py, ex, ey, bi, si;
    longint unsigned sq_dist, bd, sd;
    bit have_second;
    op = d[1:0];
    px = d[14:3];
    py = d[26:15];
    r = '0;
    bi = 0; si = 0; bd = 0; sd = 0; have_second = 0;
    if (op == OP_CLEAR) begin
      marker_total = 0;
    end else if (op == OP_LOAD) begin
      if (marker_total < MaxMarkersDef) begin
        markers[marker_total] = {d[2], d[14:3], d[26:15]};
        marker_total++;
      end else begin
        r.status = ST_FULL;
      end
    end else if (op == OP_LOCATE) begin
      if (marker_total == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int i = 0; i < marker_total; i++) begin
          ex = px - int'(markers[i][23:12]);
          ey = py - int'(markers[i][11:0]);
          sq_dist = ex * ex + ey * ey;
          if (i == 0) begin
            bd = sq_dist;
          end else if (sq_dist < bd) begin
            si = bi; sd = bd; have_second = 1;
            bi = i; bd = sq_dist;
          end else if (!have_second || sq_dist < sd) begin
            si = i; sd = sq_dist; have_second = 1;
          end
        end
        r.robot_x = markers[bi][23:12];
        r.robot_y = markers[bi][11:0];
        r.robot_id = {markers[bi][24], have_second ? markers[si][24] : 1'b0};
        r.heading = cordic_heading(px - int'(r.robot_x), py - int'(r.robot_y));
      end
    end
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    locate_result_t want, got;
    if (rst) begin
      marker_total <= 0;
      errors <= 0;
      locates_seen <= 0;
      full_seen <= 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        want = predict_marker_result(s_tdata);
        expected_results.push_back(want);
        if (s_tdata[1:0] == OP_LOCATE && want.status == ST_OK)
          locates_seen <= locates_seen + 1;
        if (want.status == ST_FULL) full_seen <= full_seen + 1;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[3:2], m_tdata[15:4], m_tdata[27:16], m_tdata[43:28]};
        if (expected_results.size() == 0) begin
          if (errors < 10) $display("unexpected transaction: %h", m_tdata);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"mismatch: exp st=%0d id=%0d x=%0d y=%0d h=%0d,",
                        " got st=%0d id=%0d x=%0d y=%0d h=%0d"},
                want.status, want.robot_id, want.robot_x, want.robot_y,
                $signed(want.heading),
                got.status, got.robot_id, got.robot_x, got.robot_y,
                $signed(got.heading));
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// File: bench/marker_pair_robot_locator_unit_test.sv
// Testbench top for the marker pair robot locator: drives directed and random
// item streams with random gaps and stalls. Needs the checker and mprl_pkg.
`timescale 1ns / 100ps
module marker_pair_robot_locator_unit_test import mprl_pkg::*;;
  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
  logic [31:0] s_tdata = '0;
  logic [47:0] m_tdata;
  int errors, pending, locates_seen, full_seen;
  int cycle_count = 0;
  bit calm = 0;
  bit hold_off = 0;

  always #2 clk = ~clk;

  marker_pair_robot_locator_unit uut (.*);
  marker_pair_robot_locator_checker check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("** marker_pair_robot_locator_unit: FAILED **");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off
  always @(posedge clk)
    m_tready <= !hold_off && (calm || $urandom_range(99) >= 22);

  // leave s_tvalid high after the accept; the next call or the caller drops it
  task automatic send_item(input logic [1:0] op, input logic g, input logic [11:0] x,
                           input logic [11:0] y);
    while (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tdata <= {5'b0, y, x, g, op};
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [11:0] near_coord(input logic [11:0] c);
    return 12'(int'(c) + $urandom_range(40) - 20);
  endfunction

  initial begin
    logic [11:0] cx, cy;
    int n;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed part
    send_item(OP_LOCATE, 0, 12'd5, 12'd5);
    send_item(OP_LOAD, 1, 12'd100, 12'd200);
    send_item(OP_LOCATE, 0, 12'd100, 12'd200);
    send_item(OP_LOCATE, 1, 12'd4095, 12'd4095);
    send_item(OP_LOCATE, 0, 12'd0, 12'd200);
    send_item(OP_LOAD, 0, 12'd4095, 12'd0);
    send_item(OP_LOAD, 1, 12'd0, 12'd4095);
    send_item(OP_LOAD, 0, 12'd100, 12'd200);
    send_item(OP_LOCATE, 0, 12'd0, 12'd0);
    send_item(OP_LOCATE, 0, 12'd4095, 12'd4095);
    send_item(OP_LOCATE, 0, 12'd2047, 12'd2048);
    send_item(2'd3, 1, 12'hfff, 12'hfff);
    send_item(OP_CLEAR, 1, 12'hfff, 12'hfff);
    send_item(OP_LOCATE, 0, 12'd1, 12'd1);
    for (int i = 0; i < 66; i++) send_item(OP_LOAD, i[0], 12'($urandom), 12'($urandom));
    send_item(OP_LOCATE, 0, 12'd1000, 12'd3000);
    // sender pauses until all results are back
    drain;
    // receiver holds off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 6; i++) send_item(OP_LOCATE, 0, 12'($urandom), 12'($urandom));
        s_tvalid <= 0;
      end
    join
    // random sets: clear, small marker clusters, locates near them or now and then a random item
    while (n < 660) begin
      calm = (n > 300 && n < 400);
      send_item(OP_CLEAR, 1'($urandom), 12'($urandom), 12'($urandom));
      n++;
      cx = 12'($urandom);
      cy = 12'($urandom);
      repeat ($urandom_range(1, $urandom_range(9) == 0 ? 66 : 6)) begin
        send_item(OP_LOAD, 1'($urandom), near_coord(cx), near_coord(cy));
        n++;
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(9) == 0)
          send_item(2'($urandom), 1'($urandom), 12'($urandom), 12'($urandom));
        else
          send_item(OP_LOCATE, 1'($urandom), near_coord(cx), near_coord(cy));
        n++;
      end
      if (n > 2000) break;
    end
    calm = 0;
    drain;
    $display("ran %0d random items, %0d successful locates, %0d loads into a full store",
             n, locates_seen, full_seen);
    if (errors == 0) begin
      $display("** marker_pair_robot_locator_unit: PASSED **");
    end else begin
      $display("** marker_pair_robot_locator_unit: FAILED **");
    end
    $finish;
  end
endmodule
